FILE: sv/smalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared sizes, codes, types and helpers of the small matrix ALU.
// ----------------------------------------------------------------------------
package smalu_pkg;

    localparam int MAX_DIM = 4;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CFG_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int OIDX_W  = 4;
    localparam int ACC_W   = 2 * VAL_W - FRAC_W + $clog2(MAX_DIM) + 1;

    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_MUL,
        B_ACC,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              op;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] value;
    } item_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (int'(r) > MAX_DIM)
            d = DIM_W'(MAX_DIM);
        else
            d = DIM_W'(r);
        return d;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}})))
            r = {1'b0, {(VAL_W-1){1'b1}}};
        else if (v < -ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}})) - ACC_W'(1))
            r = {1'b1, {(VAL_W-1){1'b0}}};
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/smalu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_if
// Valid/ready channels of the small matrix ALU: request and result.
// ----------------------------------------------------------------------------
interface smalu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [3:0]  elem_index;
    logic signed [smalu_pkg::VAL_W-1:0] value;

    modport source (output valid, kind, op, elem_index, value, input ready);
    modport sink   (input valid, kind, op, elem_index, value, output ready);
endinterface

interface smalu_out_if;
    logic        valid;
    logic        ready;
    logic [smalu_pkg::OIDX_W-1:0]       out_index;
    logic signed [smalu_pkg::VAL_W-1:0] out_value;
    logic        last;

    modport source (output valid, out_index, out_value, last, input ready);
    modport sink   (input valid, out_index, out_value, last, output ready);
endinterface

FILE: sv/smalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_front
// Takes request beats, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module smalu_front (
    input  logic                clk,
    input  logic                rst_n,
    smalu_in_if.sink            in_ch,
    output logic                q_valid,
    output smalu_pkg::item_t    q_item,
    input  logic                q_pop
);

    smalu_pkg::item_t q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       keep;
    logic       push;
    logic       pop;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        case (in_ch.kind)
            smalu_pkg::KIND_LOAD_A,
            smalu_pkg::KIND_LOAD_B:  keep = (int'(in_ch.elem_index) < smalu_pkg::DEPTH);
            smalu_pkg::KIND_COMPUTE: keep = (in_ch.op inside {smalu_pkg::OP_ADD,
                                                              smalu_pkg::OP_SUB,
                                                              smalu_pkg::OP_MUL});
            default:                 keep = 1'b0;
        endcase
    end

    assign push    = accept && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg].kind  <= in_ch.kind;
            q_mem_reg[wr_ptr_reg].op    <= in_ch.op;
            q_mem_reg[wr_ptr_reg].addr  <= smalu_pkg::ADDR_W'(in_ch.elem_index);
            q_mem_reg[wr_ptr_reg].value <= in_ch.value;
        end
    end

endmodule

FILE: sv/smalu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_back
// Holds both matrix stores, runs loads and computes, registers the results.
// ----------------------------------------------------------------------------
module smalu_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  smalu_pkg::item_t             q_item,
    output logic                         q_pop,
    input  logic [smalu_pkg::DIM_W-1:0]  ra,
    input  logic [smalu_pkg::DIM_W-1:0]  ca,
    input  logic [smalu_pkg::DIM_W-1:0]  cb,
    smalu_out_if.source                  out_ch
);

    localparam int ADDR_W = smalu_pkg::ADDR_W;
    localparam int IDX_W  = smalu_pkg::IDX_W;
    localparam int ACC_W  = smalu_pkg::ACC_W;
    localparam int VAL_W  = smalu_pkg::VAL_W;

    logic signed [VAL_W-1:0] a_mem [smalu_pkg::DEPTH];
    logic signed [VAL_W-1:0] b_mem [smalu_pkg::DEPTH];
    logic signed [VAL_W-1:0] a_rd_reg;
    logic signed [VAL_W-1:0] b_rd_reg;

    smalu_pkg::back_state_t state_reg, state_next;
    logic [1:0]               op_reg;
    logic [IDX_W-1:0]         i_reg, j_reg, k_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic                     out_valid_reg;
    logic [smalu_pkg::OIDX_W-1:0] out_index_reg;
    logic signed [VAL_W-1:0]  out_value_reg;
    logic                     out_last_reg;

    logic                     is_mul;
    logic [smalu_pkg::DIM_W-1:0] nc;
    logic                     k_last, j_last, i_last, el_last;
    logic [ADDR_W-1:0]        a_addr, b_addr;
    logic                     we_a, we_b, start, emit, out_free;

    assign is_mul   = (op_reg == smalu_pkg::OP_MUL);
    assign nc       = is_mul ? cb : ca;
    assign k_last   = (int'(k_reg) == int'(ca) - 1);
    assign j_last   = (int'(j_reg) == int'(nc) - 1);
    assign i_last   = (int'(i_reg) == int'(ra) - 1);
    assign el_last  = i_last && j_last;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        if (is_mul)
        begin
            a_addr = ADDR_W'(int'(k_reg) * int'(ra) + int'(i_reg));
            b_addr = ADDR_W'(int'(j_reg) * int'(ca) + int'(k_reg));
        end
        else
        begin
            a_addr = ADDR_W'(int'(j_reg) * int'(ra) + int'(i_reg));
            b_addr = a_addr;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smalu_pkg::B_IDLE:
                if (q_valid && q_item.kind == smalu_pkg::KIND_COMPUTE)
                    state_next = smalu_pkg::B_RD;
            smalu_pkg::B_RD:
                state_next = smalu_pkg::B_MUL;
            smalu_pkg::B_MUL:
                state_next = is_mul ? smalu_pkg::B_ACC : smalu_pkg::B_EMIT;
            smalu_pkg::B_ACC:
                state_next = k_last ? smalu_pkg::B_EMIT : smalu_pkg::B_RD;
            smalu_pkg::B_EMIT:
                if (out_free)
                    state_next = el_last ? smalu_pkg::B_IDLE : smalu_pkg::B_RD;
            default:
                state_next = smalu_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = 1'b0;
        we_a  = 1'b0;
        we_b  = 1'b0;
        start = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            smalu_pkg::B_IDLE:
            begin
                q_pop = q_valid;
                we_a  = q_valid && (q_item.kind == smalu_pkg::KIND_LOAD_A);
                we_b  = q_valid && (q_item.kind == smalu_pkg::KIND_LOAD_B);
                start = q_valid && (q_item.kind == smalu_pkg::KIND_COMPUTE);
            end
            smalu_pkg::B_EMIT:
                emit = out_free;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
            a_mem[q_item.addr] <= q_item.value;
        if (we_b)
            b_mem[q_item.addr] <= q_item.value;
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smalu_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= q_item.op;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        if (state_reg == smalu_pkg::B_MUL)
        begin
            if (is_mul)
                prod_reg <= a_rd_reg * b_rd_reg;
            else if (op_reg == smalu_pkg::OP_ADD)
                acc_reg <= ACC_W'(a_rd_reg) + ACC_W'(b_rd_reg);
            else
                acc_reg <= ACC_W'(a_rd_reg) - ACC_W'(b_rd_reg);
        end
        if (state_reg == smalu_pkg::B_ACC)
        begin
            // drop the low fraction bits: floor of the product
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> smalu_pkg::FRAC_W);
            if (!k_last)
                k_reg <= k_reg + IDX_W'(1);
        end
        if (emit)
        begin
            out_index_reg <= smalu_pkg::OIDX_W'(int'(i_reg) * int'(nc) + int'(j_reg));
            out_value_reg <= smalu_pkg::sat32(acc_reg);
            out_last_reg  <= el_last;
            acc_reg       <= '0;
            k_reg         <= '0;
            if (j_last)
            begin
                j_reg <= '0;
                i_reg <= i_reg + IDX_W'(1);
            end
            else
                j_reg <= j_reg + IDX_W'(1);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_index = out_index_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.last      = out_last_reg;

endmodule

FILE: sv/small_matrix_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_alu
// Small fixed-point matrix add, subtract and multiply unit.
// ----------------------------------------------------------------------------
// Use: set rows_a, cols_a, cols_b on the cfg port (index 0..2) while idle.
// Send load beats (kind 0 for A, 1 for B) with a column-major elem_index and
// a Q16.16 value, then a compute beat (kind 2) with op add, sub or mul.
// Each compute returns its elements row by row on the result channel, one
// beat each, with last on the final one.
// The request channel feeds a two-entry queue; a load is written to its store
// when the back end takes it off the queue, which it does only while idle.
// A compute runs element by element: a registered read of both stores, then
// add, subtract or multiply, and for multiply an accumulate per cols_a term
// on the single multiplier; each result then passes the result register.
// When the receiver stalls, the result register holds, the compute waits,
// and the queue fills until request ready drops.
// Reset empties the queue and result register and sets all sizes to 2; store
// contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module small_matrix_alu (
    input  logic                            clk,
    input  logic                            rst_n,
    smalu_in_if.sink                        in_ch,
    smalu_out_if.source                     out_ch,
    input  logic                            cfg_we,
    input  logic [smalu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smalu_pkg::CFG_W-1:0]     cfg_data
);

    logic [smalu_pkg::CFG_W-1:0] rows_a_reg, cols_a_reg, cols_b_reg;
    logic             q_valid;
    logic             q_pop;
    smalu_pkg::item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= smalu_pkg::CFG_W'(2);
            cols_a_reg <= smalu_pkg::CFG_W'(2);
            cols_b_reg <= smalu_pkg::CFG_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smalu_pkg::REG_ROWS_A: rows_a_reg <= cfg_data;
                smalu_pkg::REG_COLS_A: cols_a_reg <= cfg_data;
                smalu_pkg::REG_COLS_B: cols_b_reg <= cfg_data;
                default:               rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    smalu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    smalu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .ra      (smalu_pkg::eff_dim(rows_a_reg)),
        .ca      (smalu_pkg::eff_dim(cols_a_reg)),
        .cb      (smalu_pkg::eff_dim(cols_b_reg)),
        .out_ch  (out_ch)
    );

endmodule

FILE: verif/matrix_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_result_checker
// Watches the request, result and register ports of the small matrix ALU,
// keeps its own copy of both stores and the size registers, works out the
// elements each compute must return and compares every result beat with
// the oldest element still owed.
// ----------------------------------------------------------------------------
module matrix_result_checker
    import smalu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    smalu_in_if                  in_ch,
    smalu_out_if                 out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   owed_count
);

    typedef struct {
        logic [OIDX_W-1:0]       index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } matrix_elem_t;

    logic signed [VAL_W-1:0] a_mem [DEPTH];
    logic signed [VAL_W-1:0] b_mem [DEPTH];
    logic [CFG_W-1:0]        rows_a_q, cols_a_q, cols_b_q;
    matrix_elem_t            owed_elems[$];

    assign owed_count = owed_elems.size();

    function automatic int dim_clamp(input logic [CFG_W-1:0] r);
        if (r == 0)
            return 1;
        if (int'(r) > MAX_DIM)
            return MAX_DIM;
        return int'(r);
    endfunction

    function automatic logic signed [VAL_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[VAL_W-1:0];
    endfunction

    task automatic predict_matrix_op(input logic [1:0] op);
        int           ra, ca, cb, ncol;
        longint       acc, prod;
        matrix_elem_t e;
        ra = dim_clamp(rows_a_q);
        ca = dim_clamp(cols_a_q);
        cb = dim_clamp(cols_b_q);
        ncol = (op == OP_MUL) ? cb : ca;
        for (int i = 0; i < ra; i++)
        begin
            for (int j = 0; j < ncol; j++)
            begin
                if (op == OP_MUL)
                begin
                    acc = 0;
                    for (int k = 0; k < ca; k++)
                    begin
                        prod = longint'(a_mem[k*ra + i]) * longint'(b_mem[j*ca + k]);
                        // arithmetic shift drops the fraction toward minus infinity
                        acc += prod >>> FRAC_W;
                    end
                end
                else if (op == OP_ADD)
                    acc = longint'(a_mem[j*ra + i]) + longint'(b_mem[j*ra + i]);
                else
                    acc = longint'(a_mem[j*ra + i]) - longint'(b_mem[j*ra + i]);
                e.index = OIDX_W'(i*ncol + j);
                e.value = clip32(acc);
                e.last  = (i == ra - 1) && (j == ncol - 1);
                owed_elems = {owed_elems, e};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        matrix_elem_t e;
        if (!rst_n)
        begin
            rows_a_q   <= 3'd2;
            cols_a_q   <= 3'd2;
            cols_b_q   <= 3'd2;
            fail_count <= 0;
            owed_elems.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROWS_A: rows_a_q <= cfg_data;
                    REG_COLS_A: cols_a_q <= cfg_data;
                    REG_COLS_B: cols_b_q <= cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.kind)
                    KIND_LOAD_A: a_mem[in_ch.elem_index] = in_ch.value;
                    KIND_LOAD_B: b_mem[in_ch.elem_index] = in_ch.value;
                    KIND_COMPUTE:
                        if (in_ch.op inside {OP_ADD, OP_SUB, OP_MUL})
                            predict_matrix_op(in_ch.op);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_elems.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with none owed: idx %0d val %h last %b",
                                 $realtime, out_ch.out_index, out_ch.out_value, out_ch.last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = owed_elems.pop_front();
                    if (e.index !== out_ch.out_index || e.value !== out_ch.out_value
                        || e.last !== out_ch.last)
                    begin
                        if (fail_count < 10)
                            $display("%0t: exp idx %0d val %h last %b, got idx %0d val %h last %b",
                                     $realtime, e.index, e.value, e.last,
                                     out_ch.out_index, out_ch.out_value, out_ch.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the small matrix ALU: fills both stores, then runs directed
// and random load/compute traffic over a sweep of matrix sizes, with random
// idling on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import smalu_pkg::*;

    localparam int STALL_LIMIT = 3000;
    // codes the block must ignore
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [1:0] OP_NONE   = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   fail_count, owed_count;
    int                   hold_cycles = 0;
    bit                   calm = 1'b0;
    int                   quiet_cycles = 0;

    smalu_in_if  in_ch ();
    smalu_out_if out_ch ();

    always #5 clk = ~clk;

    small_matrix_alu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    matrix_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.kind       = '0;
        in_ch.op         = '0;
        in_ch.elem_index = '0;
        in_ch.value      = '0;
        out_ch.ready     = 1'b0;
    end

    // result side: random stalls, or a counted hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 32);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] kind, input logic [1:0] op,
                             input logic [3:0] idx, input logic [31:0] val);
        int gap;
        if (!calm && $urandom_range(99) < 32)
        begin
            gap = $urandom_range(1, 2);
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid      = 1'b1;
        in_ch.kind       = kind;
        in_ch.op         = op;
        in_ch.elem_index = idx;
        in_ch.value      = val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (owed_count != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_sizes(input logic [2:0] ra, input logic [2:0] ca, input logic [2:0] cb);
        drain_outputs();
        // hold while a trailing load retires
        repeat (20) @(negedge clk);
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_COLS_B, cb);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1:
                case ($urandom_range(4))
                    0: v = 32'h7fffffff;
                    1: v = 32'h80000000;
                    2: v = 32'hffffffff;
                    3: v = 32'h00010000;
                    default: v = 32'h0;
                endcase
            default:
            begin
                v = $urandom_range(32'h0005ffff);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic random_traffic(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 55)
                send_beat($urandom_range(1) ? KIND_LOAD_B : KIND_LOAD_A, 2'($urandom()),
                          4'($urandom()), pick_value());
            else if (sel < 90)
                send_beat(KIND_COMPUTE, 2'($urandom_range(2)), 4'($urandom()), $urandom());
            else if (sel < 95)
                send_beat(KIND_NONE, 2'($urandom()), 4'($urandom()), $urandom());
            else
                send_beat(KIND_COMPUTE, OP_NONE, 4'($urandom()), $urandom());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every entry of both stores so no compute reads an unwritten one
        for (int i = 0; i < DEPTH; i++)
        begin
            send_beat(KIND_LOAD_A, OP_ADD, 4'(i),
                      (i == 0) ? 32'h7fffffff : (i == 15) ? 32'h80000000 : pick_value());
            send_beat(KIND_LOAD_B, OP_ADD, 4'(i),
                      (i == 0) ? 32'h7fffffff : (i == 15) ? 32'hffffffff : pick_value());
        end
        send_beat(KIND_COMPUTE, OP_ADD, 4'hf, 32'h0);
        send_beat(KIND_COMPUTE, OP_SUB, 4'h0, 32'h0);
        send_beat(KIND_COMPUTE, OP_MUL, 4'h0, 32'h0);
        send_beat(KIND_NONE, OP_MUL, 4'h5, 32'h12345678);
        send_beat(KIND_COMPUTE, OP_NONE, 4'ha, 32'hffffffff);

        set_sizes(3'd4, 3'd4, 3'd4);
        send_beat(KIND_COMPUTE, OP_MUL, 4'h0, 32'h0);
        send_beat(KIND_COMPUTE, OP_SUB, 4'h0, 32'h0);
        send_beat(KIND_LOAD_A, OP_ADD, 4'h3, 32'h80000000);
        send_beat(KIND_COMPUTE, OP_ADD, 4'h0, 32'h0);

        // block fills behind a long result hold-off
        hold_cycles = 300;
        random_traffic(30);

        set_sizes(3'd1, 3'd1, 3'd1);
        send_beat(KIND_COMPUTE, OP_MUL, 4'h0, 32'h0);
        random_traffic(25);

        set_sizes(3'd0, 3'd7, 3'd5);
        calm = 1'b1;
        random_traffic(30);
        calm = 1'b0;

        set_sizes(3'd3, 3'd2, 3'd4);
        random_traffic(15);
        drain_outputs();
        random_traffic(15);

        set_sizes(3'd6, 3'd0, 3'd3);
        random_traffic(30);

        set_sizes(3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)));
        random_traffic(30);

        drain_outputs();
        repeat (50) @(negedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
